FILE: design/fmp_pkg.sv
// Package for the Fibonacci matrix power block: control word layout, microcode
// program, step addresses and the overflow threshold function.
// No dependencies.
`timescale 1ns / 1ps

package fmp_pkg;

  localparam int INDEX_BITS_DEF = 32;
  localparam int VALUE_BITS_DEF = 64;
  localparam int IN_W = 32;
  localparam int OUT_W = 64;
  localparam int HALF_W = 32;
  localparam int PC_W = 5;

  localparam logic [PC_W-1:0] ST_ROUND = PC_W'(0);
  localparam logic [PC_W-1:0] ST_SQUARE = PC_W'(14);
  localparam logic [PC_W-1:0] ST_DONE = PC_W'(28);

  typedef enum logic [2:0] {
    OPD_B0,
    OPD_B1,
    OPD_B3,
    OPD_A1,
    OPD_A3
  } opd_e;

  typedef enum logic [1:0] {
    DST_NONE,
    DST_TMP,
    DST_A,
    DST_B
  } dst_e;

  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_BIT_CLEAR,
    JMP_ALWAYS,
    JMP_LAST,
    JMP_WAIT
  } jmp_e;

  typedef struct packed {
    logic            mul_en;
    opd_e            sel_x;
    opd_e            sel_y;
    logic            hi_x;
    logic            hi_y;
    logic            first;
    dst_e            dst;
    logic            upd_b0;
    logic            shift_exp;
    jmp_e            jmp;
    logic [PC_W-1:0] target;
  } ucw_t;

  // Largest index whose Fibonacci number still fits in vbits bits.
  function automatic int last_fit(input int vbits);
    logic [64:0] a;
    logic [64:0] b;
    logic [64:0] t;
    logic [64:0] m;
    int          n;
    logic        stop;
    a = '0;
    b = 65'(1);
    n = 1;
    stop = 1'b0;
    m = (65'(1) << vbits) - 65'(1);
    for (int i = 0; i < 100; i++) begin
      if (!stop) begin
        if (b <= m - a) begin
          t = a + b;
          a = b;
          b = t;
          n++;
        end else begin
          stop = 1'b1;
        end
      end
    end
    return n;
  endfunction

  function automatic ucw_t mul_cw(input opd_e x, input opd_e y, input logic hx,
                                  input logic hy, input logic first, input dst_e dst);
    ucw_t w;
    w = '0;
    w.mul_en = 1'b1;
    w.sel_x = x;
    w.sel_y = y;
    w.hi_x = hx;
    w.hi_y = hy;
    w.first = first;
    w.dst = dst;
    w.jmp = JMP_NEXT;
    return w;
  endfunction

  function automatic ucw_t ctl_cw(input dst_e dst, input logic upd_b0, input logic shift_exp,
                                  input jmp_e jmp, input logic [PC_W-1:0] target);
    ucw_t w;
    w = '0;
    w.dst = dst;
    w.upd_b0 = upd_b0;
    w.shift_exp = shift_exp;
    w.jmp = jmp;
    w.target = target;
    return w;
  endfunction

  // The accumulated product A = B * A and the square B = B * B are powers of the
  // Fibonacci matrix, so only the entries 1 and 3 are computed; entry 2 equals
  // entry 1 and entry 0 is their sum.
  function automatic ucw_t ucode_rom(input logic [PC_W-1:0] pc);
    ucw_t w;
    case (pc)
      5'd0:  w = ctl_cw(DST_NONE, 1'b0, 1'b0, JMP_BIT_CLEAR, ST_SQUARE);
      5'd1:  w = mul_cw(OPD_B0, OPD_A1, 1'b0, 1'b0, 1'b1, DST_NONE);
      5'd2:  w = mul_cw(OPD_B0, OPD_A1, 1'b0, 1'b1, 1'b0, DST_NONE);
      5'd3:  w = mul_cw(OPD_B0, OPD_A1, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd4:  w = mul_cw(OPD_B1, OPD_A3, 1'b0, 1'b0, 1'b0, DST_NONE);
      5'd5:  w = mul_cw(OPD_B1, OPD_A3, 1'b0, 1'b1, 1'b0, DST_NONE);
      5'd6:  w = mul_cw(OPD_B1, OPD_A3, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd7:  w = mul_cw(OPD_B1, OPD_A1, 1'b0, 1'b0, 1'b1, DST_TMP);
      5'd8:  w = mul_cw(OPD_B1, OPD_A1, 1'b0, 1'b1, 1'b0, DST_NONE);
      5'd9:  w = mul_cw(OPD_B1, OPD_A1, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd10: w = mul_cw(OPD_B3, OPD_A3, 1'b0, 1'b0, 1'b0, DST_NONE);
      5'd11: w = mul_cw(OPD_B3, OPD_A3, 1'b0, 1'b1, 1'b0, DST_NONE);
      5'd12: w = mul_cw(OPD_B3, OPD_A3, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd13: w = ctl_cw(DST_A, 1'b0, 1'b0, JMP_LAST, ST_DONE);
      5'd14: w = mul_cw(OPD_B0, OPD_B1, 1'b0, 1'b0, 1'b1, DST_NONE);
      5'd15: w = mul_cw(OPD_B0, OPD_B1, 1'b0, 1'b1, 1'b0, DST_NONE);
      5'd16: w = mul_cw(OPD_B0, OPD_B1, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd17: w = mul_cw(OPD_B1, OPD_B3, 1'b0, 1'b0, 1'b0, DST_NONE);
      5'd18: w = mul_cw(OPD_B1, OPD_B3, 1'b0, 1'b1, 1'b0, DST_NONE);
      5'd19: w = mul_cw(OPD_B1, OPD_B3, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd20: w = mul_cw(OPD_B1, OPD_B1, 1'b0, 1'b0, 1'b1, DST_TMP);
      5'd21: w = mul_cw(OPD_B1, OPD_B1, 1'b0, 1'b1, 1'b0, DST_NONE);
      5'd22: w = mul_cw(OPD_B1, OPD_B1, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd23: w = mul_cw(OPD_B3, OPD_B3, 1'b0, 1'b0, 1'b0, DST_NONE);
      5'd24: w = mul_cw(OPD_B3, OPD_B3, 1'b0, 1'b1, 1'b0, DST_NONE);
      5'd25: w = mul_cw(OPD_B3, OPD_B3, 1'b1, 1'b0, 1'b0, DST_NONE);
      5'd26: w = ctl_cw(DST_B, 1'b0, 1'b0, JMP_NEXT, ST_ROUND);
      5'd27: w = ctl_cw(DST_NONE, 1'b1, 1'b1, JMP_ALWAYS, ST_ROUND);
      default: w = ctl_cw(DST_NONE, 1'b0, 1'b0, JMP_WAIT, ST_DONE);
    endcase
    return w;
  endfunction

endpackage

FILE: design/fibonacci_matrix_power.sv
// Fibonacci number by square-and-multiply of the Fibonacci matrix, driven by a
// microcode program on one shared 32x32 multiplier. Depends on fmp_pkg.
`timescale 1ns / 1ps
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | in_valid_i / in_ready_o | index_i
//  out     | output    | out_valid_o/out_ready_i | fib_value_o, overflowed_o
//
// An index of 0 or 1 goes straight to the done state and gives its result from
// the initial matrix. For a larger index n each set bit of n-1 below its top bit
// costs a multiply and a square, each clear bit a square alone, and the top bit a
// multiply; the partial product sequence per matrix entry on the single
// multiplier sets the run time.
// One item is worked on at a time; a new item is taken while a result waits.
// A finished computation holds until the output register is free.
// Reset is asynchronous and active low and leaves the block idle and empty.

module fibonacci_matrix_power #(
  parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEF,
  parameter int VALUE_BITS = fmp_pkg::VALUE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [fmp_pkg::IN_W-1:0] index_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [fmp_pkg::OUT_W-1:0] fib_value_o,
  output logic                     overflowed_o
);

  localparam int NB = (INDEX_BITS < fmp_pkg::IN_W) ? INDEX_BITS : fmp_pkg::IN_W;
  localparam logic [NB-1:0] LAST_FIT = NB'(fmp_pkg::last_fit(VALUE_BITS));
  localparam int PC_W = fmp_pkg::PC_W;
  localparam int HW = fmp_pkg::HALF_W;

  logic                  busy_q, busy_d;
  logic [PC_W-1:0]       pc_q, pc_d;
  logic                  pvalid_q;
  logic                  out_valid_q;
  logic                  pfirst_q, pshift_q;
  logic [2*HW-1:0]       prod_q;
  logic [VALUE_BITS-1:0] acc_q, tmp_q;
  logic [VALUE_BITS-1:0] b0_q, b1_q, b3_q, a1_q, a3_q;
  logic [NB-1:0]         exp_q;
  logic                  ovf_pend_q;
  logic [VALUE_BITS-1:0] fib_q;
  logic                  ovf_q;

  fmp_pkg::ucw_t         cw;
  logic                  accept;
  logic                  out_free;
  logic                  finish;
  logic                  run;
  logic [NB-1:0]         n_in;
  logic [VALUE_BITS-1:0] opd_x, opd_y;
  logic [2*HW-1:0]       x64, y64;
  logic [HW-1:0]         x_half, y_half;
  logic [2*HW-1:0]       prod_d;
  logic [2*HW-1:0]       addend;
  logic [VALUE_BITS-1:0] acc_sum;

  assign cw = fmp_pkg::ucode_rom(pc_q);
  assign n_in = index_i[NB-1:0];
  assign in_ready_o = !busy_q;
  assign accept = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    busy_d = busy_q;
    pc_d = pc_q;
    finish = 1'b0;
    if (accept) begin
      busy_d = 1'b1;
      pc_d = (n_in <= NB'(1)) ? fmp_pkg::ST_DONE : fmp_pkg::ST_ROUND;
    end else if (busy_q) begin
      case (cw.jmp)
        fmp_pkg::JMP_NEXT: pc_d = PC_W'(pc_q + 1'b1);
        fmp_pkg::JMP_BIT_CLEAR: pc_d = exp_q[0] ? PC_W'(pc_q + 1'b1) : cw.target;
        fmp_pkg::JMP_ALWAYS: pc_d = cw.target;
        fmp_pkg::JMP_LAST: pc_d = (exp_q[NB-1:1] == '0) ? cw.target : PC_W'(pc_q + 1'b1);
        fmp_pkg::JMP_WAIT: begin
          if (out_free) begin
            finish = 1'b1;
            busy_d = 1'b0;
          end
        end
        default: pc_d = fmp_pkg::ST_DONE;
      endcase
    end
  end

  always_comb begin
    run = busy_q;
    case (cw.sel_x)
      fmp_pkg::OPD_B0: opd_x = b0_q;
      fmp_pkg::OPD_B1: opd_x = b1_q;
      fmp_pkg::OPD_B3: opd_x = b3_q;
      fmp_pkg::OPD_A1: opd_x = a1_q;
      fmp_pkg::OPD_A3: opd_x = a3_q;
      default: opd_x = '0;
    endcase
    case (cw.sel_y)
      fmp_pkg::OPD_B0: opd_y = b0_q;
      fmp_pkg::OPD_B1: opd_y = b1_q;
      fmp_pkg::OPD_B3: opd_y = b3_q;
      fmp_pkg::OPD_A1: opd_y = a1_q;
      fmp_pkg::OPD_A3: opd_y = a3_q;
      default: opd_y = '0;
    endcase
  end

  assign x64 = (2*HW)'(opd_x);
  assign y64 = (2*HW)'(opd_y);
  assign x_half = cw.hi_x ? x64[2*HW-1:HW] : x64[HW-1:0];
  assign y_half = cw.hi_y ? y64[2*HW-1:HW] : y64[HW-1:0];
  assign prod_d = {{HW{1'b0}}, x_half} * {{HW{1'b0}}, y_half};

  assign addend = pshift_q ? {prod_q[HW-1:0], {HW{1'b0}}} : prod_q;
  assign acc_sum = (pfirst_q ? '0 : acc_q) + addend[VALUE_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q <= fmp_pkg::ST_DONE;
      pvalid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      pc_q <= pc_d;
      pvalid_q <= run && cw.mul_en;
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    pfirst_q <= cw.first;
    pshift_q <= cw.hi_x || cw.hi_y;
    if (pvalid_q) begin
      acc_q <= acc_sum;
    end
    if (accept) begin
      ovf_pend_q <= n_in > LAST_FIT;
      exp_q <= n_in - NB'(1);
      b0_q <= VALUE_BITS'(1);
      b1_q <= VALUE_BITS'(1);
      b3_q <= '0;
      if (n_in <= NB'(1)) begin
        a1_q <= VALUE_BITS'(n_in[0]);
        a3_q <= '0;
      end else begin
        a1_q <= '0;
        a3_q <= VALUE_BITS'(1);
      end
    end else if (run) begin
      case (cw.dst)
        fmp_pkg::DST_TMP: tmp_q <= acc_sum;
        fmp_pkg::DST_A: begin
          a1_q <= tmp_q;
          a3_q <= acc_sum;
        end
        fmp_pkg::DST_B: begin
          b1_q <= tmp_q;
          b3_q <= acc_sum;
        end
        default: begin
        end
      endcase
      if (cw.upd_b0) begin
        b0_q <= b1_q + b3_q;
      end
      if (cw.shift_exp) begin
        exp_q <= exp_q >> 1;
      end
    end
    if (finish) begin
      fib_q <= a1_q + a3_q;
      ovf_q <= ovf_pend_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign fib_value_o = fmp_pkg::OUT_W'(fib_q);
  assign overflowed_o = ovf_q;

endmodule
